// ===== rtl/kect_pkg.sv =====
// Package for the keyed event coalescing table: constants, item types, queue entry.
// No dependencies.
`default_nettype none
package kect_pkg;
  localparam int Depth = 16;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [32:0] WaitCap = 33'd2147483;
  localparam logic [30:0] MsPerSec = 31'd1000;

  localparam logic [1:0] OpSubmit = 2'd0;
  localparam logic [1:0] OpSweep = 2'd1;
  localparam logic [1:0] OpFlush = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [1:0] KindStatus = 2'd0;
  localparam logic [1:0] KindEntry = 2'd1;
  localparam logic [1:0] KindEnd = 2'd2;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StReject = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [31:0] key_id;
    logic [7:0] priority_req;
    logic [15:0] hold_seconds;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [31:0] out_key;
    logic [7:0] out_priority;
    logic [15:0] event_count;
    logic has_next;
    logic [30:0] next_wait_ms;
    logic last;
  } out_item_t;

  // command handed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [31:0] key;
    logic [7:0] prio;
    logic [32:0] expiry;
    logic [32:0] now;
    logic reject;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle, StMatch, StDrain, StWait, StMul, StEnd
  } back_state_e;
endpackage
`default_nettype wire

// ===== rtl/kect_front.sv =====
// Front: accepts items, drops unused opcodes, flags zero hold, queues commands.
// Depends on kect_pkg.
`default_nettype none
module kect_front import kect_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_item_t in_i,
  output logic          busy_o,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_pop_i
);
  cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, rd_q, push;
  cmd_t c;

  // classify
  always_comb begin
    c.op = in_i.op;
    c.key = in_i.key_id;
    c.prio = in_i.priority_req;
    c.now = {1'b0, in_i.now_seconds};
    c.expiry = {1'b0, in_i.now_seconds} + {17'd0, in_i.hold_seconds};
    c.reject = (in_i.hold_seconds == 16'd0);
  end

  assign busy_o = (cnt_q == 2'd2);
  assign push = start_i && !busy_o && (in_i.op != OpUnused);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};

  // two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end
endmodule
`default_nettype wire

// ===== rtl/kect_back.sv =====
// Back: table of slots, submit lookup, newest-first drain, wait calculation.
// Depends on kect_pkg.
`default_nettype none
module kect_back import kect_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output out_item_t res_o
);
  logic [Depth-1:0] valid_q, valid_d;
  logic [31:0] key_q [Depth];
  logic [7:0] prio_q [Depth];
  logic [15:0] cnt_q [Depth];
  logic [32:0] exp_q [Depth];
  logic [IdxW-1:0] rank_q [Depth];
  logic [CntW-1:0] total_q, total_d, kept_q, kept_d;
  logic [CntW-1:0] r_q, r_d;
  back_state_e st_q, st_d;
  cmd_t c_q;
  logic hn_q, hn_d;
  logic [32:0] near_q, near_d;
  logic [30:0] ms_q;
  logic [32:0] diff;

  logic [Depth-1:0] hit, rk;
  logic any_hit, any_free;
  logic [IdxW-1:0] hit_i, free_i, rk_i;
  logic emit, keep, ins, coal, drop;

  // match key, free slot and current rank
  always_comb begin
    hit_i = '0; free_i = '0; rk_i = '0;
    for (int i = 0; i < Depth; i++) begin
      hit[i] = valid_q[i] && key_q[i] == c_q.key;
      rk[i] = valid_q[i] && {1'b0, rank_q[i]} == r_q;
    end
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hit[i]) hit_i = IdxW'(i);
      if (!valid_q[i]) free_i = IdxW'(i);
      if (rk[i]) rk_i = IdxW'(i);
    end
    any_hit = |hit;
    any_free = ~&valid_q;
  end

  assign diff = near_q - c_q.now;

  // sequencer
  always_comb begin
    st_d = st_q; valid_d = valid_q; total_d = total_q; kept_d = kept_q;
    r_d = r_q; hn_d = hn_q; near_d = near_q;
    cmd_pop_o = 1'b0; res_valid_o = 1'b0; res_o = '0;
    emit = 1'b0; keep = 1'b0; ins = 1'b0; coal = 1'b0; drop = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1; r_d = '0; kept_d = '0; hn_d = 1'b0;
          st_d = (cmd_i.op == OpSubmit) ? StMatch : StDrain;
        end
      end
      StMatch: begin
        res_valid_o = 1'b1; res_o.kind = KindStatus; res_o.last = 1'b1;
        st_d = StIdle;
        if (c_q.reject) res_o.status = StReject;
        else if (any_hit) coal = 1'b1;
        else if (total_q >= CntW'(Depth) || !any_free) res_o.status = StFull;
        else begin
          ins = 1'b1; valid_d[free_i] = 1'b1; total_d = total_q + 1'b1;
        end
      end
      StDrain: begin
        if (r_q >= total_q) begin
          total_d = kept_q;
          st_d = hn_q ? StWait : StEnd;
        end else begin
          r_d = r_q + 1'b1;
          if (c_q.op == OpFlush || exp_q[rk_i] <= c_q.now) begin
            emit = 1'b1; valid_d[rk_i] = 1'b0;
            res_valid_o = 1'b1; res_o.kind = KindEntry;
            res_o.out_key = key_q[rk_i]; res_o.out_priority = prio_q[rk_i];
            res_o.event_count = cnt_q[rk_i];
          end else begin
            keep = 1'b1; kept_d = kept_q + 1'b1;
            if (!hn_q || exp_q[rk_i] < near_q) near_d = exp_q[rk_i];
            hn_d = 1'b1;
          end
        end
      end
      StWait: st_d = StMul;
      StMul: st_d = StEnd;
      StEnd: begin
        res_valid_o = 1'b1; res_o.kind = KindEnd; res_o.last = 1'b1;
        res_o.has_next = hn_q; res_o.next_wait_ms = hn_q ? ms_q : '0;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    drop = emit;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; valid_q <= '0; total_q <= '0;
      kept_q <= '0; r_q <= '0; hn_q <= 1'b0;
    end else begin
      st_q <= st_d; valid_q <= valid_d; total_q <= total_d;
      kept_q <= kept_d; r_q <= r_d; hn_q <= hn_d;
    end
  end

  // slot payload and wait pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) c_q <= cmd_i;
    near_q <= near_d;
    if (st_q == StWait) ms_q <= 31'((diff > WaitCap) ? WaitCap : diff);
    if (st_q == StMul) ms_q <= 31'(ms_q[21:0] * MsPerSec);
    if (coal) begin
      if (cnt_q[hit_i] != CountMax) cnt_q[hit_i] <= cnt_q[hit_i] + 16'd1;
      exp_q[hit_i] <= c_q.expiry;
    end
    if (ins) begin
      for (int j = 0; j < Depth; j++)
        if (valid_q[j]) rank_q[j] <= rank_q[j] + 1'b1;
      key_q[free_i] <= c_q.key; prio_q[free_i] <= c_q.prio;
      cnt_q[free_i] <= 16'd1; exp_q[free_i] <= c_q.expiry;
      rank_q[free_i] <= '0;
    end
    if (keep && !drop) rank_q[rk_i] <= kept_q[IdxW-1:0];
  end
endmodule
`default_nettype wire

// ===== rtl/keyed_event_coalescing_table_top.sv =====
// Keyed event coalescing table: a submit's status item follows the command queue entry
// and the back's command register. A sweep or flush is popped, steps one rank per cycle
// through total_q ranks (an entry item for each emitted rank), takes a closing step,
// then gives the end item, after StWait and StMul when a wait in ms is computed.
// A two-entry command queue accepts items while the table works; busy when full.
// Asynchronous active-low reset empties the table and queue. Results cannot stall.
`default_nettype none
module keyed_event_coalescing_table_top import kect_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_i,
  output logic          strobe_o,
  output out_item_t     res_o
);
  logic cv, pop;
  cmd_t cmd;

  // accept and queue
  kect_front u_front (
    .clk_i, .rst_ni, .start_i(start), .in_i, .busy_o(busy),
    .cmd_valid_o(cv), .cmd_o(cmd), .cmd_pop_i(pop)
  );

  // execute
  kect_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_i(cmd), .cmd_pop_o(pop),
    .res_valid_o(strobe_o), .res_o
  );
endmodule
`default_nettype wire

// ===== verif/kect_checker.sv =====
// Checker for the keyed event coalescing table: watches accepted items and results,
// predicts results from its own copy of the table and compares. Depends on kect_pkg.
`timescale 1ns / 100ps
module kect_checker import kect_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_i,
  input  wire logic      strobe_o,
  input  wire out_item_t res_o,
  output int             fail_count,
  output int             pending_results,
  output int             entries_seen,
  output int             full_seen
);
  // shadow table
  logic        tbl_valid [Depth];
  logic [31:0] tbl_key [Depth];
  logic [7:0]  tbl_prio [Depth];
  logic [15:0] tbl_count [Depth];
  logic [32:0] tbl_expiry [Depth];
  int          tbl_rank [Depth];
  int          tbl_total;

  out_item_t awaited_results[$];

  assign pending_results = awaited_results.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic out_item_t blank_result(input logic [1:0] kind);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  // Work out the results of one accepted item and update the table
  task automatic predict_table_op(input in_item_t it);
    out_item_t r;
    int        free_slot;
    int        hit;
    int        order[$];
    int        kept;
    logic      have_near;
    logic [32:0] nearest;
    logic [32:0] diff;
    logic [32:0] now33;
    now33 = {1'b0, it.now_seconds};
    if (it.op == OpSubmit) begin
      r = blank_result(KindStatus);
      hit = -1;
      free_slot = -1;
      if (it.hold_seconds == 0) begin
        r.status = StReject;
      end else begin
        for (int i = 0; i < Depth; i++)
          if (tbl_valid[i] && tbl_key[i] == it.key_id && hit < 0) hit = i;
        if (hit >= 0) begin
          if (tbl_count[hit] != CountMax) tbl_count[hit]++;
          tbl_expiry[hit] = now33 + it.hold_seconds;
        end else if (tbl_total >= Depth) begin
          r.status = StFull;
          full_seen++;
        end else begin
          for (int i = Depth - 1; i >= 0; i--)
            if (!tbl_valid[i]) free_slot = i;
          for (int j = 0; j < Depth; j++)
            if (tbl_valid[j]) tbl_rank[j]++;
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot] = it.key_id;
          tbl_prio[free_slot] = it.priority_req;
          tbl_count[free_slot] = 16'd1;
          tbl_expiry[free_slot] = now33 + it.hold_seconds;
          tbl_rank[free_slot] = 0;
          tbl_total++;
        end
      end
      awaited_results.push_back(r);
    end else if (it.op == OpSweep || it.op == OpFlush) begin
      // newest first
      for (int rk = 0; rk < tbl_total; rk++)
        for (int i = 0; i < Depth; i++)
          if (tbl_valid[i] && tbl_rank[i] == rk) order.push_back(i);
      kept = 0;
      have_near = 1'b0;
      nearest = '0;
      foreach (order[n]) begin
        int s;
        s = order[n];
        if (it.op == OpFlush || tbl_expiry[s] <= now33) begin
          r = '0;
          r.kind = KindEntry;
          r.out_key = tbl_key[s];
          r.out_priority = tbl_prio[s];
          r.event_count = tbl_count[s];
          awaited_results.push_back(r);
          entries_seen++;
          tbl_valid[s] = 1'b0;
        end else begin
          tbl_rank[s] = kept++;
          if (!have_near || tbl_expiry[s] < nearest) begin
            nearest = tbl_expiry[s];
            have_near = 1'b1;
          end
        end
      end
      tbl_total = kept;
      r = blank_result(KindEnd);
      if (have_near) begin
        diff = nearest - now33;
        if (diff > WaitCap) diff = WaitCap;
        r.has_next = 1'b1;
        r.next_wait_ms = diff[30:0] * MsPerSec;
      end
      awaited_results.push_back(r);
    end
  endtask

  // Track accepted items and compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count <= 0;
      entries_seen <= 0;
      full_seen <= 0;
      tbl_total = 0;
      for (int i = 0; i < Depth; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_rank[i] = 0;
      end
      awaited_results.delete();
    end else begin
      if (strobe_o) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", res_o));
        end else begin
          out_item_t exp_r;
          exp_r = awaited_results.pop_front();
          if (res_o.kind !== exp_r.kind) report_mismatch("kind");
          if (res_o.status !== exp_r.status) report_mismatch("status");
          if (res_o.out_key !== exp_r.out_key) report_mismatch("out_key");
          if (res_o.out_priority !== exp_r.out_priority) report_mismatch("out_priority");
          if (res_o.event_count !== exp_r.event_count) report_mismatch("event_count");
          if (res_o.has_next !== exp_r.has_next) report_mismatch("has_next");
          if (res_o.next_wait_ms !== exp_r.next_wait_ms) report_mismatch("next_wait_ms");
          if (res_o.last !== exp_r.last) report_mismatch("last");
        end
      end
      if (start && !busy) predict_table_op(in_i);
    end
  end
endmodule

// ===== verif/tb.sv =====
// Testbench top for keyed_event_coalescing_table_top: drives submits, sweeps, flushes
// and unused ops with random gaps; kect_checker predicts results. Depends on kect_pkg.
`timescale 1ns / 100ps
module tb;
  import kect_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  in_i;
  logic      strobe_o;
  out_item_t res_o;
  int        fail_count;
  int        pending_results;
  int        entries_seen;
  int        full_seen;
  int        cycle_count;
  int        idle_pct;
  int        items_sent;
  logic [31:0] clock_now;
  logic [31:0] key_pool [8];

  keyed_event_coalescing_table_top dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .strobe_o, .res_o
  );

  kect_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .in_i, .strobe_o, .res_o,
    .fail_count, .pending_results, .entries_seen, .full_seen
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("keyed_event_coalescing_table_top regression: fail");
      $finish;
    end
  end

  // Hand one item over, holding start until accepted, with a random gap first
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [31:0] key,
                         input logic [7:0] prio, input logic [15:0] hold,
                         input logic [31:0] now);
    in_item_t it;
    it.op = op;
    it.key_id = key;
    it.priority_req = prio;
    it.hold_seconds = hold;
    it.now_seconds = now;
    send_item(it);
  endtask

  // Stop sending and hold until every expected result has come
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] key;
    int sel;
    cycle_count = 0;
    items_sent = 0;
    idle_pct = 0;
    clock_now = 32'd100;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero hold, field extremes, key zero, coalescing, full table, unused op
    send_op(OpSweep, '0, '0, '0, 32'd0);
    send_op(OpSubmit, 32'd0, 8'd0, 16'd0, 32'd5);
    send_op(OpSubmit, 32'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(OpSubmit, 32'hFFFF_FFFF, 8'h00, 16'd1, 32'd0);
    send_op(OpSubmit, 32'd0, 8'h55, 16'd3, 32'd0);
    send_op(OpSweep, '0, '0, '0, 32'd0);
    send_op(OpUnused, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(OpSweep, '0, '0, '0, 32'd2);
    for (int i = 0; i < 17; i++)
      send_op(OpSubmit, 32'hA000_0000 + i, i[7:0], 16'd10 + i[15:0], 32'd10);
    send_op(OpSubmit, 32'hA000_0003, 8'h11, 16'd50, 32'd11);
    send_op(OpSweep, '0, '0, '0, 32'd22);
    send_op(OpFlush, '0, '0, '0, 32'd0);
    wait_drained();

    // Random phases with differing sender gaps
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 83 : (ph == 2) ? 7 : 40;
      foreach (key_pool[k]) key_pool[k] = $urandom;
      for (int n = 0; n < 45; n++) begin
        sel = $urandom_range(99);
        clock_now = clock_now + $urandom_range(4);
        if (sel < 70) begin
          key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(7)];
          if ($urandom_range(9) == 0) key = 32'hFFFF_FFFF;
          send_op(OpSubmit, key, 8'($urandom), ($urandom_range(19) == 0) ? 16'd0 :
                  ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)),
                  ($urandom_range(29) == 0) ? $urandom : clock_now);
        end else if (sel < 90) begin
          send_op(OpSweep, $urandom, 8'($urandom), 16'($urandom), clock_now);
        end else if (sel < 97) begin
          send_op(OpFlush, $urandom, 8'($urandom), 16'($urandom), $urandom);
        end else begin
          send_op(OpUnused, $urandom, 8'($urandom), 16'($urandom), $urandom);
        end
        if (n == 30) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("items sent: %0d, entries emitted: %0d, full refusals: %0d",
             items_sent, entries_seen, full_seen);
    $display("covered submits with coalescing, zero hold and full table, sweeps, flushes");
    if (fail_count == 0 && pending_results == 0) begin
      $display("keyed_event_coalescing_table_top regression: pass");
    end else begin
      $display("keyed_event_coalescing_table_top regression: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/kect_pkg.sv
rtl/kect_front.sv
rtl/kect_back.sv
rtl/keyed_event_coalescing_table_top.sv
verif/kect_checker.sv
verif/tb.sv
